[rtl/core/hccp_pkg.sv]
package hccp_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RGB  = 2'd1,
        MODE_HSV  = 2'd2,
        MODE_WORD = 2'd3
    } t_mode;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [3:0] COUNT_MAX    = 4'd15;
    localparam logic [3:0] DIGIT_SLOTS  = 4'd8;
    localparam logic [3:0] WORD_LEN     = 4'd4;

    typedef struct packed {
        logic load_char;
        logic load_bytes;
        logic calc_chroma;
        logic calc_x;
        logic load_out;
    } t_cmd;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] none_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h6e;
            2'd1:    r = 8'h6f;
            2'd2:    r = 8'h6e;
            default: r = 8'h65;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/hex_color_code_parser.sv]
// Colour code parser. Characters of a code arrive one per transfer, the last one flagged;
// '#' starts an RGB code, '%' an HSV code (3, 4, 6 or 8 hex digits), and the word "none"
// in any case gives all zeros. One result follows each flagged character. After a flagged
// character, byte assembly, the chroma multiply, the hue multiply and the final add each
// occupy one step of the controller, and no input is taken during those steps. The final
// step lasts longer while an earlier result still waits to be taken. The result sits in
// an output register, so further characters of the next code are taken while it waits.
module hex_color_code_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha,
    output logic       o_invalid
);

    hccp_pkg::t_cmd cmd;

    hccp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_last (i_is_last),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (cmd)
    );

    hccp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char_code (i_char_code),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha),
        .o_invalid   (o_invalid)
    );

endmodule

[rtl/core/hccp_ctrl.sv]
module hccp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_is_last,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output hccp_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BYTES  = 5'b00010,
        S_CHROMA = 5'b00100,
        S_XMUL   = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   fire;

    assign accept = i_valid && (r_state == S_IDLE);
    assign fire   = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_is_last) begin
                    n_state = S_BYTES;
                end
            end
            S_BYTES:  n_state = S_CHROMA;
            S_CHROMA: n_state = S_XMUL;
            S_XMUL:   n_state = S_FIN;
            S_FIN: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_cmd.load_char   = accept;
        o_cmd.load_bytes  = (r_state == S_BYTES);
        o_cmd.calc_chroma = (r_state == S_CHROMA);
        o_cmd.calc_x      = (r_state == S_XMUL);
        o_cmd.load_out    = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/core/hccp_dpath.sv]
module hccp_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hccp_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_char_code,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_alpha,
    output logic           o_invalid
);

    // parse state
    hccp_pkg::t_mode r_mode, n_mode;
    logic [3:0]      r_count, n_count;
    logic            r_match, n_match;
    logic            r_bad, n_bad;
    logic [3:0]      r_digit [8];

    // conversion registers
    logic [7:0] r_h, r_s, r_v, r_a;
    logic       r_inv, r_is_hsv;
    logic [7:0] r_c, r_x;

    logic [7:0]  low_char;
    logic [4:0]  hex;
    logic        wr_digit;
    logic [3:0]  count_inc;

    logic [7:0]  b_h, b_s, b_v, b_a;
    logic        b_inv;

    logic [15:0] sv_round;
    logic [15:0] div_sum;
    logic [10:0] hue_pos;
    logic [2:0]  sector;
    logic [7:0]  frac;
    logic [8:0]  frac_sel;
    logic [16:0] x_prod;
    logic [7:0]  m_val;
    logic [7:0]  o_r, o_g, o_b;

    assign low_char  = (i_char_code >= 8'h41 && i_char_code <= 8'h5a) ?
                       (i_char_code | 8'h20) : i_char_code;
    assign hex       = hccp_pkg::hex_decode(i_char_code);
    assign count_inc = (r_count < hccp_pkg::COUNT_MAX) ? r_count + 4'd1 : r_count;

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_match  = r_match;
        n_bad    = r_bad;
        wr_digit = 1'b0;
        if (i_cmd.load_char) begin
            if (r_mode == hccp_pkg::MODE_IDLE && i_char_code == hccp_pkg::CHAR_HASH) begin
                n_mode = hccp_pkg::MODE_RGB;
            end else if (r_mode == hccp_pkg::MODE_IDLE &&
                         i_char_code == hccp_pkg::CHAR_PERCENT) begin
                n_mode = hccp_pkg::MODE_HSV;
            end else if (r_mode == hccp_pkg::MODE_IDLE || r_mode == hccp_pkg::MODE_WORD) begin
                n_mode  = hccp_pkg::MODE_WORD;
                n_count = count_inc;
                if (r_count >= hccp_pkg::WORD_LEN ||
                    low_char != hccp_pkg::none_char(r_count[1:0])) begin
                    n_match = 1'b0;
                end
            end else begin
                n_count = count_inc;
                if (!hex[4]) begin
                    n_bad = 1'b1;
                end else if (r_count < hccp_pkg::DIGIT_SLOTS) begin
                    wr_digit = 1'b1;
                end
            end
        end else if (i_cmd.load_out) begin
            n_mode  = hccp_pkg::MODE_IDLE;
            n_count = 4'd0;
            n_match = 1'b1;
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hccp_pkg::MODE_IDLE;
            r_count <= 4'd0;
            r_match <= 1'b1;
            r_bad   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_match <= n_match;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_digit) begin
            r_digit[r_count[2:0]] <= hex[3:0];
        end
    end

    // channel bytes from the stored digits
    always_comb begin
        b_h   = 8'd0;
        b_s   = 8'd0;
        b_v   = 8'd0;
        b_a   = 8'd0;
        b_inv = 1'b0;
        if (r_mode == hccp_pkg::MODE_WORD) begin
            b_inv = !(r_match && r_count == hccp_pkg::WORD_LEN);
        end else if (r_bad) begin
            b_inv = 1'b1;
        end else if (r_count == 4'd3 || r_count == 4'd4) begin
            b_h = {r_digit[0], r_digit[0]};
            b_s = {r_digit[1], r_digit[1]};
            b_v = {r_digit[2], r_digit[2]};
            b_a = (r_count == 4'd4) ? {r_digit[3], r_digit[3]} : 8'hff;
        end else if (r_count == 4'd6 || r_count == 4'd8) begin
            b_h = {r_digit[0], r_digit[1]};
            b_s = {r_digit[2], r_digit[3]};
            b_v = {r_digit[4], r_digit[5]};
            b_a = (r_count == 4'd8) ? {r_digit[6], r_digit[7]} : 8'hff;
        end else begin
            b_inv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bytes) begin
            r_h      <= b_h;
            r_s      <= b_s;
            r_v      <= b_v;
            r_a      <= b_a;
            r_inv    <= b_inv;
            r_is_hsv <= !b_inv && (r_mode == hccp_pkg::MODE_HSV);
        end
    end

    // chroma: rounded s*v / 255, division by 255 as shift and add
    assign sv_round = r_s * r_v + 16'd127;
    assign div_sum  = sv_round + {8'd0, sv_round[15:8]} + 16'd1;

    assign hue_pos  = {r_h, 2'b00} + {2'b00, r_h, 1'b0};
    assign sector   = hue_pos[10:8];
    assign frac     = hue_pos[7:0];
    assign frac_sel = sector[0] ? (9'd256 - {1'b0, frac}) : {1'b0, frac};
    assign x_prod   = r_c * frac_sel + 17'd128;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_chroma) begin
            r_c <= div_sum[15:8];
        end
        if (i_cmd.calc_x) begin
            r_x <= x_prod[15:8];
        end
    end

    assign m_val = r_v - r_c;

    always_comb begin
        unique case (sector)
            3'd0: begin o_r = r_c;  o_g = r_x;  o_b = 8'd0; end
            3'd1: begin o_r = r_x;  o_g = r_c;  o_b = 8'd0; end
            3'd2: begin o_r = 8'd0; o_g = r_c;  o_b = r_x;  end
            3'd3: begin o_r = 8'd0; o_g = r_x;  o_b = r_c;  end
            3'd4: begin o_r = r_x;  o_g = 8'd0; o_b = r_c;  end
            default: begin o_r = r_c; o_g = 8'd0; o_b = r_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_red     <= r_is_hsv ? o_r + m_val : r_h;
            o_green   <= r_is_hsv ? o_g + m_val : r_s;
            o_blue    <= r_is_hsv ? o_b + m_val : r_v;
            o_alpha   <= r_a;
            o_invalid <= r_inv;
        end
    end

endmodule
